// ===== design/snd_pkg.sv =====
// ----------------------------------------------------------------------------
// snd_pkg
// shared widths, codes and types of the sequence number duplicate window
// ----------------------------------------------------------------------------
`default_nettype none

package snd_pkg;

   localparam int SEQ_W            = 16;
   localparam int CFG_W            = 8;
   localparam int CSR_DW           = 32;
   localparam int CSR_AW           = 3;
   localparam int ALU_W            = SEQ_W + 1;
   localparam int BIT_W            = $clog2(SEQ_W);
   localparam int WINDOW_DEPTH_DEF = 128;

   localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = CFG_W'(128);
   localparam logic [0:0]       REG_WINDOW_SIZE = 1'b0;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic already_seen;
      logic too_old;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/snd_req_if.sv =====
// ----------------------------------------------------------------------------
// snd_req_if
// input channel: one sequence number per item
// ----------------------------------------------------------------------------
`default_nettype none

interface snd_req_if;
   import snd_pkg::*;

   logic             valid;
   logic             ready;
   logic [SEQ_W-1:0] seq_number;

   modport source (output valid, output seq_number, input ready);
   modport sink (input valid, input seq_number, output ready);
endinterface

`default_nettype wire

// ===== design/snd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// snd_rsp_if
// result channel: duplicate and too-old flags per item
// ----------------------------------------------------------------------------
`default_nettype none

interface snd_rsp_if;
   logic valid;
   logic ready;
   logic already_seen;
   logic too_old;

   modport source (output valid, output already_seen, output too_old, input ready);
   modport sink (input valid, input already_seen, input too_old, output ready);
endinterface

`default_nettype wire

// ===== design/seq_number_duplicate_window.sv =====
// too-old item: answered after the range check; item inside window: bitmap read and mark;
// advance by a slots: a slots cleared; advance by w or more: all w slots cleared, then modulo
// throughput: one item at a time, set by the shared add / subtract unit and its sequencer
// first item after reset or a window_size write clears w bitmap slots first
// reset clears control state; bitmap contents are cleared by that first item
// ----------------------------------------------------------------------------
// seq_number_duplicate_window
// duplicate detector for 16-bit sequence numbers over a sliding bitmap window
// ----------------------------------------------------------------------------
`default_nettype none

module seq_number_duplicate_window #(
   parameter int WINDOW_DEPTH = snd_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   snd_req_if.sink                      req_ch,
   snd_rsp_if.source                    rsp_ch,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [snd_pkg::CSR_AW-1:0]   paddr,
   input  logic [snd_pkg::CSR_DW-1:0]   pwdata,
   output logic [snd_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready
);
   import snd_pkg::*;

   logic [CFG_W-1:0] window_size_ff;
   logic             csr_write;
   logic             restart;
   logic             res_valid, res_ready;
   rsp_type          res;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign restart   = csr_write && (paddr[CSR_AW-1:2] == REG_WINDOW_SIZE);
   assign prdata    = (paddr[CSR_AW-1:2] == REG_WINDOW_SIZE) ?
                      CSR_DW'(window_size_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RST;
      end else if (restart) begin
         window_size_ff <= pwdata[CFG_W-1:0];
      end
   end

   snd_ctrl #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_ch.valid),
      .in_seq      (req_ch.seq_number),
      .in_ready    (req_ch.ready),
      .restart     (restart),
      .window_size (window_size_ff),
      .res_valid   (res_valid),
      .res         (res),
      .res_ready   (res_ready)
   );

   // output register
   assign res_ready = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.already_seen = rsp_ff.already_seen;
   assign rsp_ch.too_old      = rsp_ff.too_old;

endmodule

`default_nettype wire

// ===== design/snd_alu.sv =====
// ----------------------------------------------------------------------------
// snd_alu
// shared add / subtract unit with carry or borrow out
// ----------------------------------------------------------------------------
`default_nettype none

module snd_alu (
   input  snd_pkg::alu_op_type        op,
   input  logic [snd_pkg::ALU_W-1:0]  a,
   input  logic [snd_pkg::ALU_W-1:0]  b,
   output logic [snd_pkg::ALU_W-1:0]  res,
   output logic                       flag
);
   import snd_pkg::*;

   logic [ALU_W:0] sum;

   always_comb begin
      unique case (op)
         ALU_ADD: sum = {1'b0, a} + {1'b0, b};
         ALU_SUB: sum = {1'b0, a} - {1'b0, b};
         default: sum = '0;
      endcase
   end

   assign res  = sum[ALU_W-1:0];
   assign flag = sum[ALU_W];

endmodule

`default_nettype wire

// ===== design/snd_bitmap.sv =====
// ----------------------------------------------------------------------------
// snd_bitmap
// seen bit memory, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module snd_bitmap #(
   parameter int WINDOW_DEPTH = snd_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(WINDOW_DEPTH)-1:0] wr_addr,
   input  logic                            wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(WINDOW_DEPTH)-1:0] rd_addr,
   output logic                            rd_data
);
   logic mem_ff [WINDOW_DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/snd_ctrl.sv =====
// ----------------------------------------------------------------------------
// snd_ctrl
// sequencer: offset, range check, window advance, modulo and bitmap update
// ----------------------------------------------------------------------------
`default_nettype none

module snd_ctrl #(
   parameter int WINDOW_DEPTH = snd_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [snd_pkg::SEQ_W-1:0]   in_seq,
   output logic                        in_ready,
   input  logic                        restart,
   input  logic [snd_pkg::CFG_W-1:0]   window_size,
   output logic                        res_valid,
   output snd_pkg::rsp_type            res,
   input  logic                        res_ready
);
   import snd_pkg::*;

   localparam int SW = $clog2(WINDOW_DEPTH);
   localparam int WW = $clog2(WINDOW_DEPTH + 1);

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_CLEAR  = 13'b0000000000010,
      ST_DIFF   = 13'b0000000000100,
      ST_NEG    = 13'b0000000001000,
      ST_RANGE  = 13'b0000000010000,
      ST_INDEX  = 13'b0000000100000,
      ST_WRAP   = 13'b0000001000000,
      ST_STEP   = 13'b0000010000000,
      ST_MODADD = 13'b0000100000000,
      ST_MOD    = 13'b0001000000000,
      ST_READ   = 13'b0010000000000,
      ST_MARK   = 13'b0100000000000,
      ST_DONE   = 13'b1000000000000
   } state_type;

   state_type        state_ff, state_in;
   logic             started_ff, started_in;
   logic             clr_mod_ff, clr_mod_in;
   logic [SEQ_W-1:0] newest_ff, newest_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [SEQ_W-1:0] diff_ff, diff_in;
   logic [SEQ_W-1:0] div_ff, div_in;
   logic [ALU_W-1:0] acc_ff, acc_in;
   logic [SW-1:0]    slot_ff, slot_in;
   logic [SW-1:0]    idx_ff, idx_in;
   logic [WW-1:0]    cnt_ff, cnt_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   rsp_type          res_ff, res_in;

   logic [WW-1:0]    win;
   alu_op_type       alu_op;
   logic [ALU_W-1:0] alu_a, alu_b, alu_res;
   logic             alu_flag;
   logic [ALU_W-1:0] trial;
   logic [SW-1:0]    step_slot;
   logic             wr_en, wr_data, rd_en, rd_data;
   logic [SW-1:0]    wr_addr;

   // effective window, limited to 1..depth
   always_comb begin
      if (window_size == '0) begin
         win = WW'(1);
      end else if (32'(window_size) > WINDOW_DEPTH) begin
         win = WW'(WINDOW_DEPTH);
      end else begin
         win = WW'(window_size);
      end
   end

   snd_alu u_alu (
      .op   (alu_op),
      .a    (alu_a),
      .b    (alu_b),
      .res  (alu_res),
      .flag (alu_flag)
   );

   snd_bitmap #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign trial     = {acc_ff[SEQ_W-1:0], div_ff[SEQ_W-1]};
   assign step_slot = (alu_res[WW-1:0] == win) ? '0 : alu_res[SW-1:0];

   always_comb begin
      state_in   = state_ff;
      started_in = started_ff;
      clr_mod_in = clr_mod_ff;
      newest_in  = newest_ff;
      seq_in     = seq_ff;
      diff_in    = diff_ff;
      div_in     = div_ff;
      acc_in     = acc_ff;
      slot_in    = slot_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      bit_in     = bit_ff;
      res_in     = res_ff;
      alu_op     = ALU_ADD;
      alu_a      = '0;
      alu_b      = '0;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = 1'b0;
      rd_en      = 1'b0;
      in_ready   = 1'b0;
      res_valid  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               seq_in = in_seq;
               if (!started_ff) begin
                  started_in = 1'b1;
                  newest_in  = in_seq;
                  slot_in    = '0;
                  cnt_in     = '0;
                  clr_mod_in = 1'b0;
                  state_in   = ST_CLEAR;
               end else begin
                  state_in = ST_DIFF;
               end
            end
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[SW-1:0];
            cnt_in  = cnt_ff + WW'(1);
            if (cnt_in == win) begin
               state_in = clr_mod_ff ? ST_MODADD : ST_DIFF;
            end
         end
         ST_DIFF: begin
            alu_op   = ALU_SUB;
            alu_a    = ALU_W'(seq_ff);
            alu_b    = ALU_W'(newest_ff);
            diff_in  = alu_res[SEQ_W-1:0];
            state_in = ST_NEG;
         end
         ST_NEG: begin
            // magnitude of the signed offset
            alu_op   = ALU_SUB;
            alu_a    = diff_ff[SEQ_W-1] ? '0 : ALU_W'(diff_ff);
            alu_b    = diff_ff[SEQ_W-1] ? ALU_W'(diff_ff) : '0;
            acc_in   = ALU_W'(alu_res[SEQ_W-1:0]);
            state_in = ST_RANGE;
         end
         ST_RANGE: begin
            alu_op = ALU_SUB;
            alu_a  = acc_ff;
            alu_b  = ALU_W'(win);
            if (diff_ff[SEQ_W-1]) begin
               if (!alu_flag) begin
                  res_in   = '{already_seen: 1'b0, too_old: 1'b1};
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_INDEX;
               end
            end else if (diff_ff != '0) begin
               newest_in = seq_ff;
               if (!alu_flag) begin
                  cnt_in     = '0;
                  clr_mod_in = 1'b1;
                  state_in   = ST_CLEAR;
               end else begin
                  cnt_in   = acc_ff[WW-1:0];
                  state_in = ST_STEP;
               end
            end else begin
               state_in = ST_INDEX;
            end
         end
         ST_INDEX: begin
            alu_op = ALU_SUB;
            alu_a  = ALU_W'(slot_ff);
            alu_b  = acc_ff;
            acc_in = alu_res;
            idx_in = alu_res[SW-1:0];
            state_in = alu_flag ? ST_WRAP : ST_READ;
         end
         ST_WRAP: begin
            alu_op   = ALU_ADD;
            alu_a    = acc_ff;
            alu_b    = ALU_W'(win);
            idx_in   = alu_res[SW-1:0];
            state_in = ST_READ;
         end
         ST_STEP: begin
            alu_op  = ALU_ADD;
            alu_a   = ALU_W'(slot_ff);
            alu_b   = ALU_W'(1);
            slot_in = step_slot;
            wr_en   = 1'b1;
            wr_addr = step_slot;
            cnt_in  = cnt_ff - WW'(1);
            if (cnt_ff == WW'(1)) begin
               idx_in   = step_slot;
               state_in = ST_READ;
            end
         end
         ST_MODADD: begin
            alu_op     = ALU_ADD;
            alu_a      = ALU_W'(slot_ff);
            alu_b      = acc_ff;
            div_in     = alu_res[SEQ_W-1:0];
            acc_in     = '0;
            bit_in     = BIT_W'(SEQ_W - 1);
            clr_mod_in = 1'b0;
            state_in   = ST_MOD;
         end
         ST_MOD: begin
            // restoring remainder, one dividend bit per cycle
            alu_op = ALU_SUB;
            alu_a  = trial;
            alu_b  = ALU_W'(win);
            acc_in = alu_flag ? trial : alu_res;
            div_in = {div_ff[SEQ_W-2:0], 1'b0};
            bit_in = bit_ff - BIT_W'(1);
            if (bit_ff == '0) begin
               slot_in  = acc_in[SW-1:0];
               idx_in   = acc_in[SW-1:0];
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_MARK;
         end
         ST_MARK: begin
            res_in   = '{already_seen: rd_data, too_old: 1'b0};
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (restart) begin
         started_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         started_ff <= 1'b0;
         clr_mod_ff <= 1'b0;
         newest_ff  <= '0;
         slot_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         started_ff <= started_in;
         clr_mod_ff <= clr_mod_in;
         newest_ff  <= newest_in;
         slot_ff    <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff  <= seq_in;
      diff_ff <= diff_in;
      div_ff  <= div_in;
      acc_ff  <= acc_in;
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
      bit_ff  <= bit_in;
      res_ff  <= res_in;
   end

   assign res = res_ff;

`ifndef SYNTHESIS
   a_slot_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && started_ff) |-> (WW'(slot_ff) < win))
      else $error("newest slot outside window");

   a_result_exclusive: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !(res_ff.too_old && res_ff.already_seen))
      else $error("too old item reported as seen");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !wr_en)
      else $error("bitmap written while idle");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ready) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the sequence number duplicate window against a cycle-free predictor.
// Sequence numbers are offered through a queue-fed driver. Each accepted item
// is run through a local copy of the sliding bitmap, and the duplicate and
// too-old flags that result are queued. The monitor compares every returned
// item with the oldest queued flags. Phases change the window size over the
// register port, including its extremes, and vary sender and receiver idling.
// One phase holds the receiver off long enough to back up the input.
// ----------------------------------------------------------------------------

module tb_top;
   import snd_pkg::*;

   localparam logic [CSR_AW-1:0] WINDOW_SIZE_ADDR = CSR_AW'(4 * REG_WINDOW_SIZE);
   localparam logic [CSR_AW-1:0] SPARE_ADDR       = CSR_AW'(4);
   localparam int                HOLD_CYCLES      = 600;
   localparam int                DRAIN_CYCLES     = 200;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;
   logic              hold_off = 1'b0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int fail_count     = 0;
   int result_count   = 0;

   logic [SEQ_W-1:0] seq_backlog[$];
   rsp_type          flags_due[$];
   rsp_type          flags_want;

   // predictor state
   bit   [WINDOW_DEPTH_DEF-1:0] seen_bits;
   int                          newest_slot;
   logic [SEQ_W-1:0]            newest_number;
   bit                          started;
   logic [CFG_W-1:0]            window_reg;

   // stimulus generator state, mirrors the newest number
   logic [SEQ_W-1:0] gen_top;
   bit               gen_fresh;

   logic [SEQ_W-1:0] seq_backlog_init[21] = '{
      16'd100, 16'd100, 16'd99, 16'd101, 16'd101, 16'd229, 16'd101, 16'd102,
      16'd102, 16'd229, 16'd65535, 16'd32997, 16'd32996, 16'd32996, 16'd65535,
      16'd0, 16'd0, 16'd65535, 16'd65409, 16'd65408, 16'd1
   };

   snd_req_if req_if ();
   snd_rsp_if rsp_if ();

   seq_number_duplicate_window u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #2 clock = ~clock;

   function automatic int window_span(input logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > WINDOW_DEPTH_DEF) return WINDOW_DEPTH_DEF;
      return int'(v);
   endfunction

   function automatic rsp_type replay_check(input logic [SEQ_W-1:0] seq);
      int                 w;
      int                 offset;
      int                 idx;
      logic signed [15:0] diff;
      rsp_type            r;
      w = window_span(window_reg);
      if (!started) begin
         seen_bits     = '0;
         newest_slot   = 0;
         newest_number = seq;
         started       = 1'b1;
      end
      if (newest_slot >= w) newest_slot = 0;
      diff   = seq - newest_number;
      offset = int'(diff);
      if (offset <= -w) begin
         r.already_seen = 1'b0;
         r.too_old      = 1'b1;
         return r;
      end
      if (offset > 0) begin
         if (offset >= w) begin
            seen_bits   = '0;
            newest_slot = (newest_slot + offset) % w;
         end else begin
            for (int k = 0; k < offset; k++) begin
               newest_slot = (newest_slot + 1 >= w) ? 0 : newest_slot + 1;
               seen_bits[newest_slot] = 1'b0;
            end
         end
         newest_number = seq;
         offset        = 0;
      end
      idx = newest_slot + offset;
      if (idx < 0) idx = idx + w;
      r.already_seen = seen_bits[idx];
      r.too_old      = 1'b0;
      seen_bits[idx] = 1'b1;
      return r;
   endfunction

   task automatic note_failure(input string what);
      fail_count++;
      if (fail_count <= 10) $display("%s", what);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            flags_due.push_back(replay_check(req_if.seq_number));
            void'(seq_backlog.pop_front());
         end
         if (!req_if.valid || req_if.ready) begin
            if (seq_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_if.valid      <= 1'b1;
               req_if.seq_number <= seq_backlog[0];
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         result_count++;
         if (flags_due.size() == 0) begin
            note_failure($sformatf("result %0d arrived with no item pending", result_count));
         end else begin
            flags_want = flags_due.pop_front();
            if (rsp_if.already_seen !== flags_want.already_seen ||
                rsp_if.too_old !== flags_want.too_old) begin
               note_failure($sformatf(
                  "result %0d: already_seen exp %0b got %0b, too_old exp %0b got %0b",
                  result_count, flags_want.already_seen, rsp_if.already_seen,
                  flags_want.too_old, rsp_if.too_old));
            end
         end
      end
   end

   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == WINDOW_SIZE_ADDR) begin
         window_reg = data[CFG_W-1:0];
         started    = 1'b0;
         gen_fresh  = 1'b1;
      end
   endtask

   task automatic csr_read_check(input logic [CSR_AW-1:0] addr);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== CSR_DW'(window_reg))
         note_failure($sformatf("window_size read exp %0d got %0d", window_reg, prdata));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic wait_idle();
      while (seq_backlog.size() != 0 || flags_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic queue_random(input int count);
      int                 w;
      int                 pick;
      int                 delta;
      logic [SEQ_W-1:0]   seq;
      logic signed [15:0] ahead;
      w = window_span(window_reg);
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (gen_fresh || pick >= 90) begin
            seq = SEQ_W'($urandom_range(16'hFFFF));
         end else begin
            if (pick < 40) delta = -int'($urandom_range(w - 1, 0));
            else if (pick < 70) delta = $urandom_range(3, 1);
            else if (pick < 82) delta = $urandom_range(w + 2, 1);
            else delta = -w - 1 + int'($urandom_range(2, 0));
            seq = gen_top + SEQ_W'(delta);
         end
         ahead = seq - gen_top;
         if (gen_fresh || ahead > 0) gen_top = seq;
         gen_fresh = 1'b0;
         seq_backlog.push_back(seq);
      end
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] wsize, input int send_pct,
                            input int recv_pct, input int count, input bit hold);
      wait_idle();
      csr_write(WINDOW_SIZE_ADDR, CSR_DW'(wsize));
      csr_read_check(WINDOW_SIZE_ADDR);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      queue_random(count);
      if (hold) begin
         fork
            begin
               repeat (20) @(posedge clock);
               hold_off <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
               hold_off <= 1'b0;
            end
         join_none
      end
      wait_idle();
   endtask

   initial begin
      req_if.valid      = 1'b0;
      req_if.seq_number = '0;
      rsp_if.ready      = 1'b0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      seen_bits         = '0;
      newest_slot       = 0;
      newest_number     = '0;
      started           = 1'b0;
      window_reg        = WINDOW_SIZE_RST;
      gen_top           = '0;
      gen_fresh         = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);
      csr_read_check(WINDOW_SIZE_ADDR);

      // first item, duplicates, advances, full clear, exact -w edge and wrap
      foreach (seq_backlog_init[i]) seq_backlog.push_back(seq_backlog_init[i]);
      wait_idle();
      gen_fresh = 1'b1;

      run_phase(8'd1,   0,  0,  150, 1'b0);
      run_phase(8'd0,   78, 0,  150, 1'b0);
      run_phase(8'd255, 0,  78, 200, 1'b1);
      run_phase(8'd2,   20, 20, 150, 1'b0);
      run_phase(8'd128, 0,  0,  200, 1'b0);
      run_phase(8'd17,  78, 0,  120, 1'b0);
      run_phase(8'd200, 0,  78, 100, 1'b0);
      run_phase(8'd64,  20, 20, 150, 1'b0);

      // write to a register that does not exist, tracking must carry on
      csr_write(SPARE_ADDR, '1);
      csr_read_check(WINDOW_SIZE_ADDR);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      queue_random(60);
      wait_idle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (flags_due.size() != 0)
         note_failure($sformatf("%0d results never arrived", flags_due.size()));
      if (fail_count == 0) begin
         $display("PASS seq_number_duplicate_window");
      end else begin
         $display("FAIL seq_number_duplicate_window");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("FAIL seq_number_duplicate_window");
      $finish;
   end

endmodule
